// ===== sv/cky_pkg.sv =====
// cky_pkg: constants, types and helper functions shared by the cky recognizer files
// sizes of the rule table, string store and chart, request and sequencer codes
// no dependencies
package cky_pkg;

    localparam int MAX_LEN     = 16;
    localparam int CELL_SLOTS  = 8;
    localparam int MAX_RULES   = 16;

    localparam int SYM_W       = 8;
    localparam int CNT_W       = 16;
    localparam int REQ_W       = 2;
    localparam int LEN_OUT_W   = 5;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 24;

    localparam logic [SYM_W-1:0] LEX_MARK    = 8'd42;
    localparam logic [SYM_W-1:0] GOAL_RESET  = 8'd83;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 16'hFFFF;

    localparam int LEN_CW      = $clog2(MAX_LEN + 1);
    localparam int STR_IW      = $clog2(MAX_LEN);
    localparam int RULE_IW     = $clog2(MAX_RULES);
    localparam int RULE_CW     = $clog2(MAX_RULES + 1);
    localparam int SLOT_W      = $clog2(CELL_SLOTS);
    localparam int FILL_W      = $clog2(CELL_SLOTS + 1);
    localparam int CELLS       = MAX_LEN * MAX_LEN;
    localparam int CELL_W      = $clog2(CELLS);
    localparam int CHART_DEPTH = CELLS * CELL_SLOTS;
    localparam int CHART_AW    = $clog2(CHART_DEPTH);
    localparam int CHART_DW    = SYM_W + CNT_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_RUN    = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEX,
        ST_WB,
        ST_KF1,
        ST_KF2,
        ST_KF3,
        ST_RL,
        ST_RLW,
        ST_ML,
        ST_MLW,
        ST_BZ,
        ST_DONE
    } seq_state_t;

    // commands from the sequencer to the target cell unit
    typedef struct packed {
        logic             run_start;
        logic             clr;
        logic             ins;
        logic [SYM_W-1:0] sym;
    } tgt_cmd_t;

    // chart cell of span [a, b)
    function automatic logic [CELL_W-1:0] cell_idx(input logic [LEN_CW:0] a,
                                                   input logic [LEN_CW:0] b);
        return CELL_W'((int'(a) * MAX_LEN + int'(b) - 1) % CELLS);
    endfunction

    // chart memory address of one slot of a cell
    function automatic logic [CHART_AW-1:0] chart_addr(input logic [CELL_W-1:0] cell_no,
                                                       input logic [FILL_W-1:0] slot);
        return CHART_AW'(int'(cell_no) * CELL_SLOTS + int'(slot));
    endfunction

endpackage

// ===== sv/cky_ram.sv =====
// cky_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module cky_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cky_tgt_cell.sv =====
// cky_tgt_cell: slot registers of the chart cell being built, with insert and lookup
// depends on cky_pkg
module cky_tgt_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cky_pkg::tgt_cmd_t                cmd,
    input  logic [cky_pkg::SLOT_W-1:0]       rd_idx,
    input  logic [cky_pkg::SYM_W-1:0]        goal,
    output logic [cky_pkg::FILL_W-1:0]       fill,
    output logic                             dropped,
    output logic [cky_pkg::SYM_W-1:0]        rd_sym,
    output logic [cky_pkg::CNT_W-1:0]        rd_cnt,
    output logic                             goal_hit,
    output logic [cky_pkg::CNT_W-1:0]        goal_cnt
);
    import cky_pkg::*;

    logic [SYM_W-1:0]  sym_reg [CELL_SLOTS];
    logic [CNT_W-1:0]  cnt_reg [CELL_SLOTS];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              drop_reg, drop_next;
    logic [CELL_SLOTS-1:0] hit;

    // match of the inserted symbol against the filled slots
    always_comb begin
        for (int t = 0; t < CELL_SLOTS; t++) begin
            hit[t] = (FILL_W'(t) < fill_reg) && (sym_reg[t] == cmd.sym);
        end
    end

    // fill count and dropped flag
    always_comb begin
        fill_next = fill_reg;
        drop_next = drop_reg;
        if (cmd.run_start) begin
            drop_next = 1'b0;
        end
        if (cmd.clr) begin
            fill_next = '0;
        end else if (cmd.ins && (hit == '0)) begin
            if (fill_reg < FILL_W'(CELL_SLOTS)) begin
                fill_next = fill_reg + 1'b1;
            end else begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            drop_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            drop_reg <= drop_next;
        end
    end

    // slot payload: bump a saturating count or take a new slot
    always_ff @(posedge aclk) begin
        for (int t = 0; t < CELL_SLOTS; t++) begin
            if (cmd.ins && !cmd.clr) begin
                if (hit[t]) begin
                    if (cnt_reg[t] != COUNT_MAX) begin
                        cnt_reg[t] <= cnt_reg[t] + 1'b1;
                    end
                end else if ((hit == '0) && (FILL_W'(t) == fill_reg)) begin
                    sym_reg[t] <= cmd.sym;
                    cnt_reg[t] <= CNT_W'(1);
                end
            end
        end
    end

    // goal lookup over the filled slots
    always_comb begin
        goal_hit = 1'b0;
        goal_cnt = '0;
        for (int t = 0; t < CELL_SLOTS; t++) begin
            if ((FILL_W'(t) < fill_reg) && (sym_reg[t] == goal)) begin
                goal_hit = 1'b1;
                goal_cnt = cnt_reg[t];
            end
        end
    end

    assign fill    = fill_reg;
    assign dropped = drop_reg;
    assign rd_sym  = sym_reg[rd_idx];
    assign rd_cnt  = cnt_reg[rd_idx];

endmodule

// ===== sv/cky_recognizer.sv =====
// cky recognizer top: load, append and clear words give no word out.
// a run word is accepted, then each symbol goes through a lexical pass over the rules,
// each chart cell is written back, and each span and split fetches the fill counts, caches
// the right-cell entries and tries every rule on each left-cell entry; then the result is loaded;
// s_tready stays low from the run word until that result is loaded, one run at a time.
// reset (aresetn low, synchronous) empties rule table and string, clears overflow, goal 83.
module cky_recognizer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: rule_lhs[7:0], rule_first[15:8], rule_second[23:16], symbol[31:24]
    input  logic [cky_pkg::S_DATA_W-1:0]   s_tdata,
    // tuser: req_type[1:0]
    input  logic [cky_pkg::REQ_W-1:0]      s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: accepted[0], goal_count[16:1], string_length[21:17], overflow[22], zero[23]
    output logic [cky_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [cky_pkg::SYM_W-1:0]      cfg_wr_data
);
    import cky_pkg::*;

    seq_state_t state_reg, state_next;

    logic [SYM_W-1:0]   goal_reg;
    logic [SYM_W-1:0]   rule_lhs_reg [MAX_RULES];
    logic [SYM_W-1:0]   rule_fst_reg [MAX_RULES];
    logic [SYM_W-1:0]   rule_snd_reg [MAX_RULES];
    logic [SYM_W-1:0]   str_reg [MAX_LEN];
    logic [SYM_W-1:0]   rc_sym_reg [CELL_SLOTS];
    logic [RULE_CW-1:0] rule_cnt_reg, rule_cnt_next;
    logic [LEN_CW-1:0]  str_cnt_reg, str_cnt_next;
    logic               ovf_flag_reg, ovf_flag_next;
    logic               ovf_run_reg, ovf_run_next;
    logic [LEN_CW-1:0]  n_reg, n_next;
    logic [LEN_CW-1:0]  i_reg, i_next;
    logic [LEN_CW-1:0]  k_reg, k_next;
    logic [LEN_CW-1:0]  d_reg, d_next;
    logic [RULE_CW-1:0] z_reg, z_next;
    logic [FILL_W-1:0]  m_reg, m_next;
    logic [FILL_W-1:0]  s_reg, s_next;
    logic [FILL_W-1:0]  lfill_reg, lfill_next;
    logic [FILL_W-1:0]  rfill_reg, rfill_next;
    logic [SYM_W-1:0]   b_reg, b_next;
    logic               lex_reg, lex_next;
    logic               out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic               in_acc;
    logic               rule_we, str_we, rc_we;
    tgt_cmd_t           cmd;
    logic [FILL_W-1:0]  tgt_fill;
    logic               tgt_drop, goal_hit;
    logic [SYM_W-1:0]   tgt_sym;
    logic [CNT_W-1:0]   tgt_cnt, goal_cnt;

    logic               chart_we;
    logic [CHART_AW-1:0] chart_waddr, chart_raddr;
    logic [CHART_DW-1:0] chart_wdata, chart_rdata;
    logic               fill_we;
    logic [CELL_W-1:0]  fill_waddr, fill_raddr;
    logic [FILL_W-1:0]  fill_rdata;

    logic [LEN_CW:0]    i_x, k_x, d_x, n_x, j_x;
    logic [CELL_W-1:0]  tcell, lcell, rcell;
    logic [SYM_W-1:0]   z_lhs, z_fst, z_snd;
    logic               rhit;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // loop indices and cell addresses
    assign i_x   = {1'b0, i_reg};
    assign k_x   = {1'b0, k_reg};
    assign d_x   = {1'b0, d_reg};
    assign n_x   = {1'b0, n_reg};
    assign j_x   = lex_reg ? (i_x + 1'b1) : (i_x + d_x);
    assign tcell = cell_idx(i_x, j_x);
    assign lcell = cell_idx(i_x, k_x);
    assign rcell = cell_idx(k_x, j_x);
    assign z_lhs = rule_lhs_reg[z_reg[RULE_IW-1:0]];
    assign z_fst = rule_fst_reg[z_reg[RULE_IW-1:0]];
    assign z_snd = rule_snd_reg[z_reg[RULE_IW-1:0]];

    // second symbol of the rule present in the cached right cell
    always_comb begin
        rhit = 1'b0;
        for (int t = 0; t < CELL_SLOTS; t++) begin
            if ((FILL_W'(t) < rfill_reg) && (rc_sym_reg[t] == z_snd)) begin
                rhit = 1'b1;
            end
        end
    end

    // sequencer: next state and controls
    always_comb begin
        state_next     = state_reg;
        rule_cnt_next  = rule_cnt_reg;
        str_cnt_next   = str_cnt_reg;
        ovf_flag_next  = ovf_flag_reg;
        ovf_run_next   = ovf_run_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        d_next         = d_reg;
        z_next         = z_reg;
        m_next         = m_reg;
        s_next         = s_reg;
        lfill_next     = lfill_reg;
        rfill_next     = rfill_reg;
        b_next         = b_reg;
        lex_next       = lex_reg;
        out_valid_next = (m_tvalid && m_tready) ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        rule_we        = 1'b0;
        str_we         = 1'b0;
        rc_we          = 1'b0;
        cmd            = '0;
        chart_we       = 1'b0;
        chart_waddr    = chart_addr(tcell, s_reg);
        chart_wdata    = {tgt_cnt, tgt_sym};
        chart_raddr    = '0;
        fill_we        = 1'b0;
        fill_waddr     = tcell;
        fill_raddr     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (req_t'(s_tuser))
                        REQ_LOAD: begin
                            if (rule_cnt_reg < RULE_CW'(MAX_RULES)) begin
                                rule_we       = 1'b1;
                                rule_cnt_next = rule_cnt_reg + 1'b1;
                            end else begin
                                ovf_flag_next = 1'b1;
                            end
                        end
                        REQ_APPEND: begin
                            if (str_cnt_reg < LEN_CW'(MAX_LEN)) begin
                                str_we       = 1'b1;
                                str_cnt_next = str_cnt_reg + 1'b1;
                            end else begin
                                ovf_flag_next = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            rule_cnt_next = '0;
                            ovf_flag_next = 1'b0;
                        end
                        REQ_RUN: begin
                            n_next        = str_cnt_reg;
                            ovf_run_next  = ovf_flag_reg;
                            str_cnt_next  = '0;
                            ovf_flag_next = 1'b0;
                            cmd.run_start = 1'b1;
                            cmd.clr       = 1'b1;
                            i_next        = '0;
                            z_next        = '0;
                            lex_next      = 1'b1;
                            state_next    = (str_cnt_reg == '0) ? ST_DONE : ST_LEX;
                        end
                        default: ;
                    endcase
                end
            end
            // lexical rules against the symbol at position i
            ST_LEX: begin
                if (z_reg < rule_cnt_reg) begin
                    if ((z_fst == str_reg[i_reg[STR_IW-1:0]]) && (z_snd == LEX_MARK)) begin
                        cmd.ins = 1'b1;
                        cmd.sym = z_lhs;
                    end
                    z_next = z_reg + 1'b1;
                end else begin
                    s_next     = '0;
                    state_next = ST_WB;
                end
            end
            // write the finished target cell back, then pick the next span
            ST_WB: begin
                if (s_reg < tgt_fill) begin
                    chart_we = 1'b1;
                    s_next   = s_reg + 1'b1;
                end else begin
                    fill_we = 1'b1;
                    cmd.clr = 1'b1;
                    if (lex_reg) begin
                        if ((i_x + 1'b1) < n_x) begin
                            i_next     = i_reg + 1'b1;
                            z_next     = '0;
                            state_next = ST_LEX;
                        end else if (n_reg == LEN_CW'(1)) begin
                            cmd.clr    = 1'b0;
                            state_next = ST_DONE;
                        end else begin
                            lex_next   = 1'b0;
                            d_next     = LEN_CW'(2);
                            i_next     = '0;
                            k_next     = LEN_CW'(1);
                            state_next = ST_KF1;
                        end
                    end else if ((i_x + 1'b1 + d_x) <= n_x) begin
                        i_next     = i_reg + 1'b1;
                        k_next     = LEN_CW'(i_x + 2'd2);
                        state_next = ST_KF1;
                    end else if ((d_x + 1'b1) <= n_x) begin
                        d_next     = d_reg + 1'b1;
                        i_next     = '0;
                        k_next     = LEN_CW'(1);
                        state_next = ST_KF1;
                    end else begin
                        cmd.clr    = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            // fetch fill counts of the left and right cells of split k
            ST_KF1: begin
                fill_raddr = lcell;
                state_next = ST_KF2;
            end
            ST_KF2: begin
                lfill_next = fill_rdata;
                fill_raddr = rcell;
                state_next = ST_KF3;
            end
            ST_KF3: begin
                rfill_next = fill_rdata;
                s_next     = '0;
                state_next = ST_RL;
            end
            // cache the right cell symbols
            ST_RL: begin
                if (s_reg < rfill_reg) begin
                    chart_raddr = chart_addr(rcell, s_reg);
                    state_next  = ST_RLW;
                end else begin
                    m_next     = '0;
                    state_next = ST_ML;
                end
            end
            ST_RLW: begin
                rc_we      = 1'b1;
                s_next     = s_reg + 1'b1;
                state_next = ST_RL;
            end
            // walk the left cell entries
            ST_ML: begin
                if (m_reg < lfill_reg) begin
                    chart_raddr = chart_addr(lcell, m_reg);
                    state_next  = ST_MLW;
                end else if ((k_x + 1'b1) < j_x) begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_KF1;
                end else begin
                    s_next     = '0;
                    state_next = ST_WB;
                end
            end
            ST_MLW: begin
                b_next     = chart_rdata[SYM_W-1:0];
                z_next     = '0;
                state_next = ST_BZ;
            end
            // binary rules for one left entry
            ST_BZ: begin
                if (z_reg < rule_cnt_reg) begin
                    if ((z_snd != LEX_MARK) && (z_fst == b_reg) && rhit) begin
                        cmd.ins = 1'b1;
                        cmd.sym = z_lhs;
                    end
                    z_next = z_reg + 1'b1;
                end else begin
                    m_next     = m_reg + 1'b1;
                    state_next = ST_ML;
                end
            end
            // hand the result word to the output register
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, ovf_run_reg || tgt_drop, LEN_OUT_W'(n_reg),
                                      goal_hit ? goal_cnt : CNT_W'(0), goal_hit};
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            goal_reg      <= GOAL_RESET;
            rule_cnt_reg  <= '0;
            str_cnt_reg   <= '0;
            ovf_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rule_cnt_reg  <= rule_cnt_next;
            str_cnt_reg   <= str_cnt_next;
            ovf_flag_reg  <= ovf_flag_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                goal_reg <= cfg_wr_data;
            end
        end
    end

    // loop counters and payload
    always_ff @(posedge aclk) begin
        ovf_run_reg  <= ovf_run_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        d_reg        <= d_next;
        z_reg        <= z_next;
        m_reg        <= m_next;
        s_reg        <= s_next;
        lfill_reg    <= lfill_next;
        rfill_reg    <= rfill_next;
        b_reg        <= b_next;
        lex_reg      <= lex_next;
        out_data_reg <= out_data_next;
        if (rule_we) begin
            rule_lhs_reg[rule_cnt_reg[RULE_IW-1:0]] <= s_tdata[7:0];
            rule_fst_reg[rule_cnt_reg[RULE_IW-1:0]] <= s_tdata[15:8];
            rule_snd_reg[rule_cnt_reg[RULE_IW-1:0]] <= s_tdata[23:16];
        end
        if (str_we) begin
            str_reg[str_cnt_reg[STR_IW-1:0]] <= s_tdata[31:24];
        end
        if (rc_we) begin
            rc_sym_reg[s_reg[SLOT_W-1:0]] <= chart_rdata[SYM_W-1:0];
        end
    end

    cky_tgt_cell u_tgt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_idx   (s_reg[SLOT_W-1:0]),
        .goal     (goal_reg),
        .fill     (tgt_fill),
        .dropped  (tgt_drop),
        .rd_sym   (tgt_sym),
        .rd_cnt   (tgt_cnt),
        .goal_hit (goal_hit),
        .goal_cnt (goal_cnt)
    );

    cky_ram #(
        .WIDTH (CHART_DW),
        .DEPTH (CHART_DEPTH)
    ) u_chart (
        .aclk  (aclk),
        .we    (chart_we),
        .waddr (chart_waddr),
        .wdata (chart_wdata),
        .raddr (chart_raddr),
        .rdata (chart_rdata)
    );

    cky_ram #(
        .WIDTH (FILL_W),
        .DEPTH (CELLS)
    ) u_fill (
        .aclk  (aclk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (tgt_fill),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/cky_checker.sv =====
// cky_props: port-level checks of the cky recognizer, bound to the top level
// depends on cky_pkg and cky_recognizer
module cky_props (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [cky_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [cky_pkg::REQ_W-1:0]      s_tuser,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [cky_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [cky_pkg::SYM_W-1:0]      cfg_wr_data
);
    import cky_pkg::*;

    // result word stays up until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped before it was taken");

    // a missing goal reports a zero count
    a_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == '0)
        else $error("goal count nonzero without acceptance");

    // acceptance needs a nonempty string and a nonzero count
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[16:1] != '0) && (m_tdata[21:17] != '0))
        else $error("accepted with empty string or zero count");

    // length within the string store and pad bit clear
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:17] <= LEN_OUT_W'(MAX_LEN)) && !m_tdata[23])
        else $error("string length out of range");

    // a run word keeps the input side stalled on the next cycle
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_RUN) |=> !s_tready)
        else $error("input taken right after a run word");

endmodule

bind cky_recognizer cky_props u_chk (.*);

// ===== dv/cky_checker.sv =====
// cky_checker: watches the input, result and goal-register ports of cky_recognizer,
// predicts each run word with its own chart walk and compares field by field
// depends on cky_pkg
module cky_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [cky_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [cky_pkg::REQ_W-1:0]    s_tuser,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [cky_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         cfg_wr_en,
    input  logic [cky_pkg::SYM_W-1:0]    cfg_wr_data,
    output int                           errors,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cky_pkg::*;

    typedef struct packed {
        logic             accepted;
        logic [CNT_W-1:0] goal_count;
        logic [4:0]       string_length;
        logic             overflow;
    } verdict_t;

    verdict_t verdict_q[$];

    // predicted block state
    logic [23:0]      rules[MAX_RULES];
    int               n_rules;
    logic [SYM_W-1:0] str[MAX_LEN];
    int               n_str;
    bit               ovf;
    logic [SYM_W-1:0] goal;

    // chart model
    logic [SYM_W-1:0] ch_sym[CELLS][CELL_SLOTS];
    logic [CNT_W-1:0] ch_cnt[CELLS][CELL_SLOTS];
    int               ch_fill[CELLS];
    bit               slot_lost;

    function automatic int span_cell(int i, int j);
        return (i * MAX_LEN + j - 1) % CELLS;
    endfunction

    function automatic int find_slot(int c, logic [SYM_W-1:0] s);
        for (int k = 0; k < ch_fill[c]; k++)
            if (ch_sym[c][k] == s) return k;
        return -1;
    endfunction

    function automatic void add_sym(int c, logic [SYM_W-1:0] s);
        int at;
        at = find_slot(c, s);
        if (at >= 0) begin
            if (ch_cnt[c][at] != COUNT_MAX) ch_cnt[c][at]++;
        end else if (ch_fill[c] < CELL_SLOTS) begin
            ch_sym[c][ch_fill[c]] = s;
            ch_cnt[c][ch_fill[c]] = 1;
            ch_fill[c]++;
        end else begin
            slot_lost = 1;
        end
    endfunction

    // full cky walk over the stored string
    function automatic verdict_t recognize();
        verdict_t v;
        int n, left, right, at;
        logic [SYM_W-1:0] b;
        n = n_str;
        foreach (ch_fill[c]) ch_fill[c] = 0;
        slot_lost = 0;
        for (int i = 0; i < n; i++)
            for (int z = 0; z < n_rules; z++)
                if (rules[z][15:8] == str[i] && rules[z][7:0] == LEX_MARK)
                    add_sym(span_cell(i, i + 1), rules[z][23:16]);
        for (int d = 2; d <= n; d++)
            for (int i = 0; i + d <= n; i++)
                for (int k = i + 1; k < i + d; k++) begin
                    left = span_cell(i, k);
                    right = span_cell(k, i + d);
                    for (int m = 0; m < ch_fill[left]; m++) begin
                        b = ch_sym[left][m];
                        for (int z = 0; z < n_rules; z++)
                            if (rules[z][7:0] != LEX_MARK && rules[z][15:8] == b &&
                                find_slot(right, rules[z][7:0]) >= 0)
                                add_sym(span_cell(i, i + d), rules[z][23:16]);
                    end
                end
        v = '0;
        if (n > 0) begin
            at = find_slot(span_cell(0, n), goal);
            if (at >= 0) begin
                v.accepted = 1;
                v.goal_count = ch_cnt[span_cell(0, n)][at];
            end
        end
        v.string_length = 5'(n);
        v.overflow = ovf || slot_lost;
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t got, want;
        if (!aresetn) begin
            n_rules = 0;
            n_str = 0;
            ovf = 0;
            goal = GOAL_RESET;
            errors <= 0;
            pending <= 0;
        end else begin
            if (cfg_wr_en) goal = cfg_wr_data;
            // input word accepted
            if (s_tvalid && s_tready) begin
                case (req_t'(s_tuser))
                    REQ_LOAD: begin
                        if (n_rules < MAX_RULES) begin
                            rules[n_rules] = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
                            n_rules++;
                        end else ovf = 1;
                    end
                    REQ_APPEND: begin
                        if (n_str < MAX_LEN) begin
                            str[n_str] = s_tdata[31:24];
                            n_str++;
                        end else ovf = 1;
                    end
                    REQ_CLEAR: begin
                        n_rules = 0;
                        ovf = 0;
                    end
                    default: begin
                        verdict_q.push_back(recognize());
                        n_str = 0;
                        ovf = 0;
                    end
                endcase
            end
            // result word accepted
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[16:1], m_tdata[21:17], m_tdata[22]};
                if (verdict_q.size() == 0) begin
                    if (errors < 10) $display("unexpected result word %h", m_tdata);
                    errors <= errors + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (got != want) begin
                        if (errors < 10)
                            $display("result mismatch: acc %0d/%0d cnt %0d/%0d len %0d/%0d ovf %0d/%0d (exp/act)",
                                     want.accepted, got.accepted, want.goal_count,
                                     got.goal_count, want.string_length, got.string_length,
                                     want.overflow, got.overflow);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= verdict_q.size();
        end
    end
endmodule

// ===== dv/tb_top.sv =====
// tb_top: drives cky_recognizer with directed and random grammar, string and run words
// and gives the verdict; checking is done in cky_checker
// depends on cky_pkg, cky_recognizer, cky_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cky_pkg::*;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [REQ_W-1:0]      s_tuser = REQ_LOAD;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic                  cfg_wr_en = 0;
    logic [SYM_W-1:0]      cfg_wr_data = '0;
    int                    errors, pending;
    int                    n_items = 0;
    bit                    quiet = 0;
    logic [SYM_W-1:0]      goal_now = GOAL_RESET;

    always #5 aclk = ~aclk;

    cky_recognizer i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    cky_checker i_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .errors(errors), .pending(pending)
    );

    // result side stalls in bursts
    int stall_left = 0;
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    // one word through the input channel, with an optional gap before it
    task automatic send(req_t req, logic [7:0] lhs, logic [7:0] first,
                        logic [7:0] second, logic [7:0] sym);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= {sym, second, first, lhs};
        do @(posedge aclk); while (!s_tready);
        n_items++;
    endtask

    // goal register is written only with the block idle
    task automatic set_goal(logic [7:0] g);
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= g;
        @(posedge aclk);
        cfg_wr_en <= 0;
        goal_now = g;
    endtask

    function automatic logic [7:0] pick_nt();
        case ($urandom_range(0, 9))
            0, 1, 2: return goal_now;
            3, 4:    return 8'd65;
            5:       return 8'd66;
            6:       return 8'd67;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_term();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(97, 99));
    endfunction

    initial begin
        int nr, len;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty string, a tiny grammar, field extremes, goal extremes
        send(REQ_RUN, 0, 0, 0, 0);
        send(REQ_LOAD, 65, 97, LEX_MARK, 0);
        send(REQ_LOAD, 66, 98, LEX_MARK, 0);
        send(REQ_LOAD, 83, 65, 66, 0);
        send(REQ_LOAD, 83, 83, 83, 0);
        send(REQ_APPEND, 0, 0, 0, 97);
        send(REQ_APPEND, 0, 0, 0, 98);
        send(REQ_RUN, 0, 0, 0, 0);
        send(REQ_APPEND, 0, 0, 0, 98);
        send(REQ_APPEND, 0, 0, 0, 97);
        send(REQ_RUN, 0, 0, 0, 0);
        send(REQ_LOAD, 255, 255, 255, 255);
        send(REQ_LOAD, 0, 0, 0, 0);
        send(REQ_LOAD, 0, 255, LEX_MARK, 0);
        send(REQ_APPEND, 255, 255, 255, 255);
        send(REQ_APPEND, 0, 0, 0, 0);
        send(REQ_RUN, 255, 255, 255, 255);
        send(REQ_CLEAR, 0, 0, 0, 0);
        send(REQ_APPEND, 0, 0, 0, 97);
        send(REQ_RUN, 0, 0, 0, 0);
        set_goal(8'd0);
        send(REQ_LOAD, 0, 97, LEX_MARK, 0);
        send(REQ_APPEND, 0, 0, 0, 97);
        send(REQ_RUN, 0, 0, 0, 0);
        set_goal(8'd255);
        send(REQ_LOAD, 255, 97, LEX_MARK, 0);
        send(REQ_APPEND, 0, 0, 0, 97);
        send(REQ_RUN, 0, 0, 0, 0);

        // random grammars and strings, with some noise words
        while (n_items < 1200) begin
            if (n_items > 1100) quiet = 1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 5))
                    send(req_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0: set_goal(8'd0);
                        1: set_goal(8'd255);
                        2: set_goal(8'd83);
                        default: set_goal(8'($urandom));
                    endcase
                end
                if ($urandom_range(0, 2) == 0) send(REQ_CLEAR, 0, 0, 0, 0);
                nr = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 7);
                repeat (nr) begin
                    if ($urandom_range(0, 1) == 0)
                        send(REQ_LOAD, pick_nt(), pick_term(), LEX_MARK, 8'($urandom));
                    else
                        send(REQ_LOAD, pick_nt(), pick_nt(), pick_nt(), 8'($urandom));
                end
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 17) : $urandom_range(0, 6);
                repeat (len) send(REQ_APPEND, 8'($urandom), 8'($urandom), 8'($urandom), pick_term());
                send(REQ_RUN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        s_tvalid <= 0;

        // drain and settle
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1s;
        $display("TEST FAILED");
        $finish;
    end
endmodule
